>>> hw/rtl/nvs_pkg.sv
// Package for the nearest value search unit.
// Holds command, status and read-select codes and the controller/datapath structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package nvs_pkg;

    localparam int NVS_MAX_ENTRIES = 64;

    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_INSERT = 2'd1;
    localparam logic [1:0] CMD_QUERY  = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_DUP   = 2'd3;

    localparam logic [1:0] RD_MID    = 2'd0;
    localparam logic [1:0] RD_POS    = 2'd1;
    localparam logic [1:0] RD_POS_M1 = 2'd2;
    localparam logic [1:0] RD_IDX_M1 = 2'd3;

    localparam logic [1:0] RES_ZERO = 2'd0;
    localparam logic [1:0] RES_DATA = 2'd1;
    localparam logic [1:0] RES_PICK = 2'd2;

    typedef struct packed {
        logic       load;
        logic       clear_count;
        logic       rd_en;
        logic [1:0] rd_sel;
        logic       search_upd;
        logic       idx_load;
        logic       shift_wr;
        logic       ins_wr;
        logic       res_load;
        logic [1:0] res_status;
        logic [1:0] res_src;
        logic       below_load;
        logic       out_load;
    } nvs_cmd_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic       count_zero;
        logic       count_full;
        logic       lo_lt_hi;
        logic       pos_zero;
        logic       pos_lt_count;
        logic       rd_eq_val;
        logic       idx_gt_pos;
    } nvs_stat_t;

endpackage

`default_nettype wire

>>> hw/rtl/nvs_datapath.sv
// Datapath of the nearest value search unit: sorted value store, search bounds,
// shift index, result and output registers. Depends on nvs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module nvs_datapath
    import nvs_pkg::*;
#(
    parameter int MAX_ENTRIES = NVS_MAX_ENTRIES
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic [1:0]         s_command,
    input  wire logic signed [31:0] s_operand_value,
    input  wire nvs_cmd_t           cmd_i,
    output nvs_stat_t               stat_o,
    output logic [1:0]              m_status,
    output logic signed [31:0]      m_nearest_value
);

    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam logic [CW-1:0] MaxCount = CW'(MAX_ENTRIES);

    logic [31:0] value_store_mem [MAX_ENTRIES];

    logic [1:0]         cmd_reg;
    logic signed [31:0] val_reg;
    logic [CW-1:0]      count_reg, count_next;
    logic [CW-1:0]      lo_reg, lo_next;
    logic [CW-1:0]      hi_reg, hi_next;
    logic [CW-1:0]      idx_reg, idx_next;
    logic signed [31:0] rd_data_reg;
    logic signed [31:0] below_reg;
    logic [1:0]         res_status_reg;
    logic signed [31:0] res_value_reg;
    logic [1:0]         out_status_reg;
    logic signed [31:0] out_value_reg;

    logic [CW-1:0]      mid;
    logic [CW-1:0]      rd_idx;
    logic [CW-1:0]      wr_idx;
    logic [31:0]        wr_data;
    logic               wr_en;
    logic signed [32:0] dist_lo;
    logic signed [32:0] dist_hi;
    logic signed [31:0] pick_value;
    logic signed [31:0] res_value;

    assign mid = lo_reg + ((hi_reg - lo_reg) >> 1);

    always_comb begin
        case (cmd_i.rd_sel)
            RD_MID:    rd_idx = mid;
            RD_POS:    rd_idx = lo_reg;
            RD_POS_M1: rd_idx = lo_reg - CW'(1);
            RD_IDX_M1: rd_idx = idx_reg - CW'(1);
            default:   rd_idx = mid;
        endcase
    end

    assign wr_en   = cmd_i.shift_wr | cmd_i.ins_wr;
    assign wr_idx  = cmd_i.shift_wr ? idx_reg : lo_reg;
    assign wr_data = cmd_i.shift_wr ? rd_data_reg : val_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            value_store_mem[wr_idx[AW-1:0]] <= wr_data;
        end
        if (cmd_i.rd_en) begin
            rd_data_reg <= value_store_mem[rd_idx[AW-1:0]];
        end
    end

    assign dist_lo    = {val_reg[31], val_reg} - {below_reg[31], below_reg};
    assign dist_hi    = {rd_data_reg[31], rd_data_reg} - {val_reg[31], val_reg};
    assign pick_value = (dist_lo <= dist_hi) ? below_reg : rd_data_reg;

    always_comb begin
        case (cmd_i.res_src)
            RES_ZERO: res_value = '0;
            RES_DATA: res_value = rd_data_reg;
            RES_PICK: res_value = pick_value;
            default:  res_value = '0;
        endcase
    end

    always_comb begin
        count_next = count_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        idx_next   = idx_reg;
        if (cmd_i.load) begin
            lo_next = '0;
            hi_next = count_reg;
        end
        if (cmd_i.clear_count) begin
            count_next = '0;
        end
        if (cmd_i.search_upd) begin
            if (rd_data_reg < val_reg) begin
                lo_next = mid + CW'(1);
            end else begin
                hi_next = mid;
            end
        end
        if (cmd_i.idx_load) begin
            idx_next = count_reg;
        end
        if (cmd_i.shift_wr) begin
            idx_next = idx_reg - CW'(1);
        end
        if (cmd_i.ins_wr) begin
            count_next = count_reg + CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        lo_reg  <= lo_next;
        hi_reg  <= hi_next;
        idx_reg <= idx_next;
        if (cmd_i.load) begin
            cmd_reg <= s_command;
            val_reg <= s_operand_value;
        end
        if (cmd_i.below_load) begin
            below_reg <= rd_data_reg;
        end
        if (cmd_i.res_load) begin
            res_status_reg <= cmd_i.res_status;
            res_value_reg  <= res_value;
        end
        if (cmd_i.out_load) begin
            out_status_reg <= res_status_reg;
            out_value_reg  <= res_value_reg;
        end
    end

    assign stat_o.cmd          = cmd_reg;
    assign stat_o.count_zero   = (count_reg == '0);
    assign stat_o.count_full   = (count_reg >= MaxCount);
    assign stat_o.lo_lt_hi     = (lo_reg < hi_reg);
    assign stat_o.pos_zero     = (lo_reg == '0);
    assign stat_o.pos_lt_count = (lo_reg < count_reg);
    assign stat_o.rd_eq_val    = (rd_data_reg == val_reg);
    assign stat_o.idx_gt_pos   = (idx_reg > lo_reg);

    assign m_status        = out_status_reg;
    assign m_nearest_value = out_value_reg;

endmodule

`default_nettype wire

>>> hw/rtl/nvs_ctrl.sv
// Controller of the nearest value search unit: sequences search, insert shift
// and query steps and owns the handshakes. Depends on nvs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module nvs_ctrl
    import nvs_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    output logic           m_valid,
    input  wire logic      m_ready,
    input  wire nvs_stat_t stat_i,
    output nvs_cmd_t       cmd_o
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DECODE   = 4'd1;
    localparam logic [3:0] S_SEARCH   = 4'd2;
    localparam logic [3:0] S_SCMP     = 4'd3;
    localparam logic [3:0] S_POST     = 4'd4;
    localparam logic [3:0] S_INS_CHK  = 4'd5;
    localparam logic [3:0] S_INS_FULL = 4'd6;
    localparam logic [3:0] S_SHIFT    = 4'd7;
    localparam logic [3:0] S_SHIFT_WR = 4'd8;
    localparam logic [3:0] S_Q_ONE    = 4'd9;
    localparam logic [3:0] S_Q_BELOW  = 4'd10;
    localparam logic [3:0] S_Q_ABOVE  = 4'd11;
    localparam logic [3:0] S_FIN      = 4'd12;

    logic [3:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;

    always_comb begin
        state_next = state_reg;
        cmd_o      = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd_o.load = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                cmd_o.res_status = ST_OK;
                cmd_o.res_src    = RES_ZERO;
                case (stat_i.cmd)
                    CMD_CLEAR: begin
                        cmd_o.clear_count = 1'b1;
                        cmd_o.res_load    = 1'b1;
                        state_next        = S_FIN;
                    end
                    CMD_INSERT: begin
                        state_next = S_SEARCH;
                    end
                    CMD_QUERY: begin
                        if (stat_i.count_zero) begin
                            cmd_o.res_load   = 1'b1;
                            cmd_o.res_status = ST_EMPTY;
                            state_next       = S_FIN;
                        end else begin
                            state_next = S_SEARCH;
                        end
                    end
                    default: begin
                        cmd_o.res_load = 1'b1;
                        state_next     = S_FIN;
                    end
                endcase
            end
            S_SEARCH: begin
                if (stat_i.lo_lt_hi) begin
                    cmd_o.rd_en  = 1'b1;
                    cmd_o.rd_sel = RD_MID;
                    state_next   = S_SCMP;
                end else begin
                    state_next = S_POST;
                end
            end
            S_SCMP: begin
                cmd_o.search_upd = 1'b1;
                state_next       = S_SEARCH;
            end
            S_POST: begin
                if (stat_i.cmd == CMD_INSERT) begin
                    if (stat_i.pos_lt_count) begin
                        cmd_o.rd_en  = 1'b1;
                        cmd_o.rd_sel = RD_POS;
                        state_next   = S_INS_CHK;
                    end else begin
                        state_next = S_INS_FULL;
                    end
                end else if (stat_i.pos_zero) begin
                    cmd_o.rd_en  = 1'b1;
                    cmd_o.rd_sel = RD_POS;
                    state_next   = S_Q_ONE;
                end else if (!stat_i.pos_lt_count) begin
                    cmd_o.rd_en  = 1'b1;
                    cmd_o.rd_sel = RD_POS_M1;
                    state_next   = S_Q_ONE;
                end else begin
                    cmd_o.rd_en  = 1'b1;
                    cmd_o.rd_sel = RD_POS_M1;
                    state_next   = S_Q_BELOW;
                end
            end
            S_INS_CHK: begin
                if (stat_i.rd_eq_val) begin
                    cmd_o.res_load   = 1'b1;
                    cmd_o.res_status = ST_DUP;
                    cmd_o.res_src    = RES_ZERO;
                    state_next       = S_FIN;
                end else begin
                    state_next = S_INS_FULL;
                end
            end
            S_INS_FULL: begin
                if (stat_i.count_full) begin
                    cmd_o.res_load   = 1'b1;
                    cmd_o.res_status = ST_FULL;
                    cmd_o.res_src    = RES_ZERO;
                    state_next       = S_FIN;
                end else begin
                    cmd_o.idx_load = 1'b1;
                    state_next     = S_SHIFT;
                end
            end
            S_SHIFT: begin
                if (stat_i.idx_gt_pos) begin
                    cmd_o.rd_en  = 1'b1;
                    cmd_o.rd_sel = RD_IDX_M1;
                    state_next   = S_SHIFT_WR;
                end else begin
                    cmd_o.ins_wr     = 1'b1;
                    cmd_o.res_load   = 1'b1;
                    cmd_o.res_status = ST_OK;
                    cmd_o.res_src    = RES_ZERO;
                    state_next       = S_FIN;
                end
            end
            S_SHIFT_WR: begin
                cmd_o.shift_wr = 1'b1;
                state_next     = S_SHIFT;
            end
            S_Q_ONE: begin
                cmd_o.res_load   = 1'b1;
                cmd_o.res_status = ST_OK;
                cmd_o.res_src    = RES_DATA;
                state_next       = S_FIN;
            end
            S_Q_BELOW: begin
                cmd_o.below_load = 1'b1;
                cmd_o.rd_en      = 1'b1;
                cmd_o.rd_sel     = RD_POS;
                state_next       = S_Q_ABOVE;
            end
            S_Q_ABOVE: begin
                cmd_o.res_load   = 1'b1;
                cmd_o.res_status = ST_OK;
                cmd_o.res_src    = RES_PICK;
                state_next       = S_FIN;
            end
            S_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    cmd_o.out_load = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd_o.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/nearest_value_search_unit.sv
// Nearest value search unit: sorted set of distinct signed values with clear,
// insert and nearest-value query. One item at a time; a new item is taken while a
// result still waits in the output register. Query time is set by the binary search
// over the one read port. Insert shifts each entry at or above the insert position
// up by one, with a read and a write per shifted entry.
// Reset empties the set; the store itself is not cleared. Depends on nvs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module nearest_value_search_unit
    import nvs_pkg::*;
#(
    parameter int MAX_ENTRIES = NVS_MAX_ENTRIES
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [1:0]         s_command,
    input  wire logic signed [31:0] s_operand_value,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [1:0]              m_status,
    output logic signed [31:0]      m_nearest_value
);

    nvs_cmd_t  dp_cmd;
    nvs_stat_t dp_stat;

    nvs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat_i  (dp_stat),
        .cmd_o   (dp_cmd)
    );

    nvs_datapath #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_command       (s_command),
        .s_operand_value (s_operand_value),
        .cmd_i           (dp_cmd),
        .stat_o          (dp_stat),
        .m_status        (m_status),
        .m_nearest_value (m_nearest_value)
    );

endmodule

`default_nettype wire
